>>> sv/tppv_pkg.sv
// ----------------------------------------------------------------------------
// tppv_pkg
// Shared types, codes and the microprogram of the parabola vertex core.
// ----------------------------------------------------------------------------
package tppv_pkg;

  localparam int unsigned DefDataWidth = 32;
  localparam int unsigned DefFracBits  = 16;
  localparam int unsigned NumSlots     = 3;
  localparam int unsigned NumUops      = 22;
  localparam int unsigned UopIdxW      = 5;

  typedef enum logic [1:0] {
    ST_FEW   = 2'd0,
    ST_VALID = 2'd1,
    ST_DUP_X = 2'd2,
    ST_FLAT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic    done;
    status_e status;
  } seq_rsp_t;

  // operand and destination registers of the sequencer
  typedef enum logic [4:0] {
    R_DA, R_DB, R_DC, R_E21, R_E31, R_X0, R_Y0, R_SCALE,
    R_N2, R_DEN, R_M, R_TN, R_T1, R_T2, R_T3,
    R_VX, R_VY, R_CC
  } reg_e;

  typedef struct packed {
    alu_op_e op;
    reg_e    dst;
    reg_e    src_a;
    reg_e    src_b;
  } uop_t;

  typedef enum logic [1:0] {T_IDLE, T_START, T_BUSY, T_PUSH} top_state_e;
  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} seq_state_e;
  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_FIX, A_SAT} alu_state_e;

  // multiplies iterate over the bits of src_b, so the narrower operand goes there
  function automatic uop_t uop_rom(input logic [UopIdxW-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:    u = '{OP_MUL, R_T1,  R_E31, R_DA};
      5'd1:    u = '{OP_MUL, R_T2,  R_E21, R_DB};
      5'd2:    u = '{OP_SUB, R_N2,  R_T1,  R_T2};
      5'd3:    u = '{OP_MUL, R_T1,  R_DA,  R_DB};
      5'd4:    u = '{OP_MUL, R_DEN, R_T1,  R_DC};
      5'd5:    u = '{OP_MUL, R_T1,  R_E21, R_DB};
      5'd6:    u = '{OP_MUL, R_T1,  R_T1,  R_DC};
      5'd7:    u = '{OP_MUL, R_T2,  R_N2,  R_DA};
      5'd8:    u = '{OP_SUB, R_M,   R_T1,  R_T2};
      5'd9:    u = '{OP_ADD, R_TN,  R_N2,  R_N2};
      5'd10:   u = '{OP_MUL, R_T1,  R_TN,  R_X0};
      5'd11:   u = '{OP_SUB, R_T1,  R_T1,  R_M};
      5'd12:   u = '{OP_DIV, R_VX,  R_T1,  R_TN};
      5'd13:   u = '{OP_MUL, R_T1,  R_DEN, R_N2};
      5'd14:   u = '{OP_ADD, R_T1,  R_T1,  R_T1};
      5'd15:   u = '{OP_ADD, R_T1,  R_T1,  R_T1};
      5'd16:   u = '{OP_MUL, R_T2,  R_T1,  R_Y0};
      5'd17:   u = '{OP_MUL, R_T3,  R_M,   R_M};
      5'd18:   u = '{OP_SUB, R_T2,  R_T2,  R_T3};
      5'd19:   u = '{OP_DIV, R_VY,  R_T2,  R_T1};
      5'd20:   u = '{OP_MUL, R_T1,  R_N2,  R_SCALE};
      5'd21:   u = '{OP_DIV, R_CC,  R_T1,  R_DEN};
      default: u = '{OP_ADD, R_T3,  R_T3,  R_T3};
    endcase
    return u;
  endfunction

endpackage

>>> sv/tppv_if.sv
// ----------------------------------------------------------------------------
// tppv channel interfaces
// Valid/ready channels for incoming points and outgoing vertex results.
// ----------------------------------------------------------------------------
interface tppv_point_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] point_x;
  logic signed [DATA_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface tppv_result_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [DATA_WIDTH-1:0] vertex_x;
  logic signed [DATA_WIDTH-1:0] vertex_y;
  logic signed [DATA_WIDTH-1:0] concavity;

  modport source (output valid, output status, output vertex_x, output vertex_y,
                  output concavity, input ready);
  modport sink   (input valid, input status, input vertex_x, input vertex_y,
                  input concavity, output ready);
endinterface

>>> sv/tppv_alu.sv
// ----------------------------------------------------------------------------
// tppv_alu
// Shared wide unit: add/sub, shift-add multiply, restoring divide
// with round-half-away and saturation to the output format.
// ----------------------------------------------------------------------------
module tppv_alu #(
  parameter int unsigned DATA_WIDTH = tppv_pkg::DefDataWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tppv_pkg::alu_req_t             req_i,
  input  logic signed [6*DATA_WIDTH+12:0] a_i,
  input  logic signed [6*DATA_WIDTH+12:0] b_i,
  output logic                           done_o,
  output logic signed [6*DATA_WIDTH+12:0] res_o
);
  import tppv_pkg::*;

  localparam int unsigned MagW = 6 * DATA_WIDTH + 12;
  localparam int unsigned SumW = MagW + 1;
  localparam int unsigned CntW = $clog2(MagW + 1);
  localparam int unsigned OutW = DATA_WIDTH + 1;

  alu_state_e            state_q, state_d;
  logic [MagW-1:0]       acc_q, acc_d;
  logic [MagW-1:0]       mc_q, mc_d;
  logic [MagW-1:0]       mp_q, mp_d;
  logic [MagW-1:0]       rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic signed [SumW-1:0] res_q, res_d;
  logic                  done_q, done_d;

  logic [SumW-1:0]       abs_a, abs_b;
  logic [MagW:0]         shift_rem;
  logic [MagW+1:0]       trial;
  logic [OutW-1:0]       q_lo, lim, q_mag, q_signed;
  logic                  q_big;

  always_comb begin
    abs_a = a_i[SumW-1] ? SumW'(-a_i) : SumW'(a_i);
    abs_b = b_i[SumW-1] ? SumW'(-b_i) : SumW'(b_i);
    shift_rem = {rem_q, mc_q[MagW-1]};
    trial = {1'b0, shift_rem} - {2'b00, mp_q};
    q_big = |mc_q[MagW-1:DATA_WIDTH];
    q_lo  = {1'b0, mc_q[DATA_WIDTH-1:0]};
    lim   = neg_q ? (OutW'(1) << (DATA_WIDTH - 1))
                  : ((OutW'(1) << (DATA_WIDTH - 1)) - OutW'(1));
    q_mag    = (q_big || (q_lo > lim)) ? lim : q_lo;
    q_signed = neg_q ? (OutW'(0) - q_mag) : q_mag;
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    mc_d    = mc_q;
    mp_d    = mp_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_ADD: begin
              res_d  = a_i + b_i;
              done_d = 1'b1;
            end
            OP_SUB: begin
              res_d  = a_i - b_i;
              done_d = 1'b1;
            end
            OP_MUL: begin
              acc_d   = '0;
              mc_d    = abs_a[MagW-1:0];
              mp_d    = abs_b[MagW-1:0];
              neg_d   = a_i[SumW-1] ^ b_i[SumW-1];
              state_d = A_MUL;
            end
            OP_DIV: begin
              // round(n/d) = floor((2n + d) / 2d) on magnitudes
              mc_d    = (abs_a[MagW-1:0] << 1) + abs_b[MagW-1:0];
              mp_d    = abs_b[MagW-1:0] << 1;
              rem_d   = '0;
              cnt_d   = CntW'(MagW);
              neg_d   = a_i[SumW-1] ^ b_i[SumW-1];
              state_d = A_DIV;
            end
            default: state_d = A_IDLE;
          endcase
        end
      end
      A_MUL: begin
        if (mp_q == '0) begin
          state_d = A_FIX;
        end else begin
          if (mp_q[0]) acc_d = acc_q + mc_q;
          mc_d = mc_q << 1;
          mp_d = mp_q >> 1;
        end
      end
      A_FIX: begin
        res_d   = neg_q ? (SumW'(0) - {1'b0, acc_q}) : {1'b0, acc_q};
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      A_DIV: begin
        // quotient bits shift into the numerator register
        if (!trial[MagW+1]) begin
          rem_d = trial[MagW-1:0];
          mc_d  = {mc_q[MagW-2:0], 1'b1};
        end else begin
          rem_d = shift_rem[MagW-1:0];
          mc_d  = {mc_q[MagW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) state_d = A_SAT;
      end
      A_SAT: begin
        res_d   = {{(SumW-OutW){q_signed[OutW-1]}}, q_signed};
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/tppv_seq.sv
// ----------------------------------------------------------------------------
// tppv_seq
// Microprogram sequencer and operand registers: checks for duplicate x, then
// runs the fit through the shared unit and collects the three results.
// ----------------------------------------------------------------------------
module tppv_seq #(
  parameter int unsigned DATA_WIDTH = tppv_pkg::DefDataWidth,
  parameter int unsigned FRAC_BITS  = tppv_pkg::DefFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DATA_WIDTH-1:0] held_x_i [tppv_pkg::NumSlots],
  input  logic signed [DATA_WIDTH-1:0] held_y_i [tppv_pkg::NumSlots],
  output tppv_pkg::seq_rsp_t           rsp_o,
  output logic signed [DATA_WIDTH-1:0] vertex_x_o,
  output logic signed [DATA_WIDTH-1:0] vertex_y_o,
  output logic signed [DATA_WIDTH-1:0] concavity_o
);
  import tppv_pkg::*;

  localparam int unsigned MagW = 6 * DATA_WIDTH + 12;
  localparam int unsigned SumW = MagW + 1;
  localparam int unsigned DifW = DATA_WIDTH + 1;
  localparam logic signed [SumW-1:0] Scale = SumW'(1) << (2 * FRAC_BITS + 1);

  seq_state_e             state_q, state_d;
  logic [UopIdxW-1:0]     pc_q, pc_d;
  status_e                status_q, status_d;
  uop_t                   uop;
  alu_req_t               alu_req;
  logic                   alu_done;
  logic signed [SumW-1:0] alu_res;
  logic signed [SumW-1:0] opnd_a, opnd_b;
  logic                   dup_x, load, wr_en;

  logic signed [DifW-1:0] da, db, dc;
  logic signed [DifW-1:0] da_q, db_q, dc_q, e21_q, e31_q, x0_q, y0_q;
  logic signed [SumW-1:0] n2_q, den_q, m_q, tn_q, t1_q, t2_q, t3_q;
  logic signed [DATA_WIDTH-1:0] vx_q, vy_q, cc_q;

  always_comb begin
    da    = DifW'(held_x_i[1]) - DifW'(held_x_i[0]);
    db    = DifW'(held_x_i[2]) - DifW'(held_x_i[0]);
    dc    = DifW'(held_x_i[2]) - DifW'(held_x_i[1]);
    dup_x = (da == '0) || (db == '0) || (dc == '0);
    uop   = uop_rom(pc_q);
  end

  always_comb begin
    case (uop.src_a)
      R_DA:    opnd_a = SumW'(da_q);
      R_DB:    opnd_a = SumW'(db_q);
      R_DC:    opnd_a = SumW'(dc_q);
      R_E21:   opnd_a = SumW'(e21_q);
      R_E31:   opnd_a = SumW'(e31_q);
      R_X0:    opnd_a = SumW'(x0_q);
      R_Y0:    opnd_a = SumW'(y0_q);
      R_SCALE: opnd_a = Scale;
      R_N2:    opnd_a = n2_q;
      R_DEN:   opnd_a = den_q;
      R_M:     opnd_a = m_q;
      R_TN:    opnd_a = tn_q;
      R_T1:    opnd_a = t1_q;
      R_T2:    opnd_a = t2_q;
      R_T3:    opnd_a = t3_q;
      default: opnd_a = '0;
    endcase
    case (uop.src_b)
      R_DA:    opnd_b = SumW'(da_q);
      R_DB:    opnd_b = SumW'(db_q);
      R_DC:    opnd_b = SumW'(dc_q);
      R_E21:   opnd_b = SumW'(e21_q);
      R_E31:   opnd_b = SumW'(e31_q);
      R_X0:    opnd_b = SumW'(x0_q);
      R_Y0:    opnd_b = SumW'(y0_q);
      R_SCALE: opnd_b = Scale;
      R_N2:    opnd_b = n2_q;
      R_DEN:   opnd_b = den_q;
      R_M:     opnd_b = m_q;
      R_TN:    opnd_b = tn_q;
      R_T1:    opnd_b = t1_q;
      R_T2:    opnd_b = t2_q;
      R_T3:    opnd_b = t3_q;
      default: opnd_b = '0;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    status_d      = status_q;
    alu_req.start = 1'b0;
    alu_req.op    = uop.op;
    load          = 1'b0;
    wr_en         = 1'b0;
    rsp_o.done    = 1'b0;
    rsp_o.status  = status_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          load = 1'b1;
          pc_d = '0;
          if (dup_x) begin
            status_d = ST_DUP_X;
            state_d  = S_DONE;
          end else begin
            state_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        alu_req.start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (alu_done) begin
          wr_en = 1'b1;
          if (uop.dst == R_N2 && alu_res == '0) begin
            status_d = ST_FLAT;
            state_d  = S_DONE;
          end else if (pc_q == UopIdxW'(NumUops - 1)) begin
            status_d = ST_VALID;
            state_d  = S_DONE;
          end else begin
            pc_d    = pc_q + UopIdxW'(1);
            state_d = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        rsp_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      status_q <= ST_FEW;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      da_q  <= da;
      db_q  <= db;
      dc_q  <= dc;
      e21_q <= DifW'(held_y_i[1]) - DifW'(held_y_i[0]);
      e31_q <= DifW'(held_y_i[2]) - DifW'(held_y_i[0]);
      x0_q  <= DifW'(held_x_i[0]);
      y0_q  <= DifW'(held_y_i[0]);
      vx_q  <= '0;
      vy_q  <= '0;
      cc_q  <= '0;
    end else if (wr_en) begin
      case (uop.dst)
        R_N2:    n2_q  <= alu_res;
        R_DEN:   den_q <= alu_res;
        R_M:     m_q   <= alu_res;
        R_TN:    tn_q  <= alu_res;
        R_T1:    t1_q  <= alu_res;
        R_T2:    t2_q  <= alu_res;
        R_T3:    t3_q  <= alu_res;
        R_VX:    vx_q  <= alu_res[DATA_WIDTH-1:0];
        R_VY:    vy_q  <= alu_res[DATA_WIDTH-1:0];
        R_CC:    cc_q  <= alu_res[DATA_WIDTH-1:0];
        default: t3_q  <= t3_q;
      endcase
    end
  end

  tppv_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opnd_a),
    .b_i    (opnd_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign vertex_x_o  = vx_q;
  assign vertex_y_o  = vy_q;
  assign concavity_o = cc_q;

endmodule

>>> sv/three_point_parabola_vertex_core.sv
// ----------------------------------------------------------------------------
// three_point_parabola_vertex_core
// Keeps three points, fits a parabola and reports its vertex and concavity.
// ----------------------------------------------------------------------------
// One point is taken at a time; ready stays low until its result is handed
// to the output register. A point that leaves fewer than three held, or two
// held points with the same x, is answered without running the fit. A full
// fit runs 22 steps on one shared wide unit. A multiply steps through the
// significant bits of its second operand, and each of the three divides
// steps bit-serially through the full operand width. These bit-serial
// divides set most of the time that a point takes.
module three_point_parabola_vertex_core #(
  parameter int unsigned DATA_WIDTH = tppv_pkg::DefDataWidth,
  parameter int unsigned FRAC_BITS  = tppv_pkg::DefFracBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tppv_point_if.sink    point_i,
  tppv_result_if.source result_o
);
  import tppv_pkg::*;

  localparam int unsigned DifW = DATA_WIDTH + 1;

  top_state_e                   state_q, state_d;
  logic [1:0]                   seen_q;
  logic signed [DATA_WIDTH-1:0] held_x_q [NumSlots];
  logic signed [DATA_WIDTH-1:0] held_y_q [NumSlots];

  logic                         accept, seq_start, pend_ld_few, pend_ld_seq, out_ld;
  seq_rsp_t                     seq_rsp;
  logic signed [DATA_WIDTH-1:0] seq_vx, seq_vy, seq_cc;

  status_e                      pend_st_q;
  logic signed [DATA_WIDTH-1:0] pend_vx_q, pend_vy_q, pend_cc_q;
  logic                         out_valid_q;
  status_e                      out_st_q;
  logic signed [DATA_WIDTH-1:0] out_vx_q, out_vy_q, out_cc_q;

  logic signed [DifW-1:0]       dy [NumSlots];
  logic [DifW-1:0]              ey [NumSlots];
  logic [1:0]                   slot;

  // distance of the new y from each held y; ties go to the higher slot
  always_comb begin
    for (int k = 0; k < NumSlots; k++) begin
      dy[k] = DifW'(point_i.point_y) - DifW'(held_y_q[k]);
      ey[k] = dy[k][DifW-1] ? DifW'(-dy[k]) : DifW'(dy[k]);
    end
    if (seen_q != 2'd3) slot = seen_q;
    else if (ey[0] > ey[1]) slot = (ey[0] > ey[2]) ? 2'd0 : 2'd2;
    else slot = (ey[1] > ey[2]) ? 2'd1 : 2'd2;
  end

  always_comb begin
    state_d     = state_q;
    seq_start   = 1'b0;
    pend_ld_few = 1'b0;
    pend_ld_seq = 1'b0;
    out_ld      = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (point_i.valid) state_d = T_START;
      end
      T_START: begin
        if (seen_q != 2'd3) begin
          pend_ld_few = 1'b1;
          state_d     = T_PUSH;
        end else begin
          seq_start = 1'b1;
          state_d   = T_BUSY;
        end
      end
      T_BUSY: begin
        if (seq_rsp.done) begin
          pend_ld_seq = 1'b1;
          state_d     = T_PUSH;
        end
      end
      T_PUSH: begin
        if (!out_valid_q || result_o.ready) begin
          out_ld  = 1'b1;
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  assign accept        = point_i.valid && (state_q == T_IDLE);
  assign point_i.ready = (state_q == T_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumSlots; k++) begin
        held_x_q[k] <= '0;
        held_y_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        held_x_q[slot] <= point_i.point_x;
        held_y_q[slot] <= point_i.point_y;
        if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
      end
      if (out_ld) out_valid_q <= 1'b1;
      else if (result_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_ld_few) begin
      pend_st_q <= ST_FEW;
      pend_vx_q <= '0;
      pend_vy_q <= '0;
      pend_cc_q <= '0;
    end else if (pend_ld_seq) begin
      pend_st_q <= seq_rsp.status;
      pend_vx_q <= seq_vx;
      pend_vy_q <= seq_vy;
      pend_cc_q <= seq_cc;
    end
    if (out_ld) begin
      out_st_q <= pend_st_q;
      out_vx_q <= pend_vx_q;
      out_vy_q <= pend_vy_q;
      out_cc_q <= pend_cc_q;
    end
  end

  tppv_seq #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (seq_start),
    .held_x_i    (held_x_q),
    .held_y_i    (held_y_q),
    .rsp_o       (seq_rsp),
    .vertex_x_o  (seq_vx),
    .vertex_y_o  (seq_vy),
    .concavity_o (seq_cc)
  );

  assign result_o.valid     = out_valid_q;
  assign result_o.status    = out_st_q;
  assign result_o.vertex_x  = out_vx_q;
  assign result_o.vertex_y  = out_vy_q;
  assign result_o.concavity = out_cc_q;

endmodule

>>> sv/tppv_chk.sv
// ----------------------------------------------------------------------------
// tppv_chk
// Port-level checks of the parabola vertex core, bound to the top level.
// ----------------------------------------------------------------------------
module tppv_chk #(
  parameter int unsigned DATA_WIDTH = tppv_pkg::DefDataWidth
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [1:0]                   status_i,
  input logic signed [DATA_WIDTH-1:0] vertex_x_i,
  input logic signed [DATA_WIDTH-1:0] vertex_y_i,
  input logic signed [DATA_WIDTH-1:0] concavity_i
);
  import tppv_pkg::*;

  // one item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after an item was taken");

  a_zero_unless_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_VALID) |-> (vertex_x_i == '0) && (vertex_y_i == '0)
      && (concavity_i == '0))
    else $error("nonzero result fields without a valid fit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(vertex_x_i) && $stable(vertex_y_i) && $stable(concavity_i))
    else $error("stalled result changed");

  // a fresh result cannot appear in the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared without processing time");

endmodule

bind three_point_parabola_vertex_core tppv_chk #(
  .DATA_WIDTH(DATA_WIDTH)
) u_tppv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .status_i    (result_o.status),
  .vertex_x_i  (result_o.vertex_x),
  .vertex_y_i  (result_o.vertex_y),
  .concavity_i (result_o.concavity)
);
